### rtl/sbo_pkg.sv
// ----------------------------------------------------------------------------
// sbo_pkg
// Shared widths, codes and control types of the slab bitmap object allocator.
// ----------------------------------------------------------------------------
package sbo_pkg;

    localparam int ADDR_W      = 32;  // address ports and base register
    localparam int SIZE_W      = 18;  // object size register
    localparam int CNT_W       = 13;  // slot count, in-use count, slot number
    localparam int SPAN_W      = CNT_W + SIZE_W;
    localparam int WORD_BITS   = 64;  // bitmap word
    localparam int WORD_SEL_W  = $clog2(WORD_BITS);
    localparam int REG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int DEF_MAX_OBJECTS = 4096;
    localparam int DEF_ADDR_BITS   = 32;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_BASE_ADDR   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_OBJ_SIZE    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_NUM_OBJECTS = 2'd2;

    localparam logic [SIZE_W-1:0] RST_OBJ_SIZE    = 18'd32;
    localparam logic [CNT_W-1:0]  RST_NUM_OBJECTS = 13'd4096;

    // request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADADDR  = 2'd2;
    localparam logic [1:0] ST_NOTALLOC = 2'd3;

    typedef struct packed {
        logic       clr_step;
        logic       load_req;
        logic       scan_init;
        logic       scan_run;
        logic       alloc_wr;
        logic       off_calc;
        logic       div_init;
        logic       div_step;
        logic       free_rd;
        logic       free_wr;
        logic       finish;
        logic       fin_sum;
        logic [1:0] fin_status;
    } ctl_t;

    typedef struct packed {
        logic clr_last;
        logic scan_hit;
        logic scan_miss;
        logic off_bad;
        logic div_last;
        logic rem_nz;
        logic slot_set;
    } sts_t;

    // lowest clear bit of a bitmap word: {found, position}
    function automatic logic [WORD_SEL_W:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_SEL_W:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = {1'b1, WORD_SEL_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

### rtl/sbo_ctrl.sv
// ----------------------------------------------------------------------------
// sbo_ctrl
// Request sequencer: bitmap clear after reset, allocate scan, free checks.
// ----------------------------------------------------------------------------
module sbo_ctrl import sbo_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic cmd,
    input  sts_t sts,
    output ctl_t ctl,
    output logic busy
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_AWR   = 4'd3;
    localparam logic [3:0] S_AADD  = 4'd4;
    localparam logic [3:0] S_OFFS  = 4'd5;
    localparam logic [3:0] S_RCHK  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_FCHK  = 4'd8;
    localparam logic [3:0] S_FRD   = 4'd9;
    localparam logic [3:0] S_FDONE = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load_req  = 1'b1;
                    ctl.scan_init = 1'b1;
                    state_next    = (cmd == CMD_FREE) ? S_OFFS : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    state_next = S_AWR;
                end
                else if (sts.scan_miss)
                begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = ST_FULL;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctl.scan_run = 1'b1;
                end
            end
            S_AWR:
            begin
                ctl.alloc_wr = 1'b1;
                state_next   = S_AADD;
            end
            S_AADD:
            begin
                ctl.finish     = 1'b1;
                ctl.fin_sum    = 1'b1;
                ctl.fin_status = ST_OK;
                state_next     = S_IDLE;
            end
            S_OFFS:
            begin
                ctl.off_calc = 1'b1;
                state_next   = S_RCHK;
            end
            S_RCHK:
            begin
                if (sts.off_bad)
                begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = ST_BADADDR;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctl.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                // off a slot boundary
                if (sts.rem_nz)
                begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = ST_BADADDR;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctl.free_rd = 1'b1;
                    state_next  = S_FRD;
                end
            end
            S_FRD:
            begin
                if (sts.slot_set)
                begin
                    ctl.free_wr = 1'b1;
                    state_next  = S_FDONE;
                end
                else
                begin
                    ctl.finish     = 1'b1;
                    ctl.fin_status = ST_NOTALLOC;
                    state_next     = S_IDLE;
                end
            end
            S_FDONE:
            begin
                ctl.finish     = 1'b1;
                ctl.fin_status = ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### rtl/sbo_dp.sv
// ----------------------------------------------------------------------------
// sbo_dp
// Bitmap memory, word scanner, offset and range check, slot divider,
// in-use counter and result registers.
// ----------------------------------------------------------------------------
module sbo_dp import sbo_pkg::*;
#(
    parameter int MAX_OBJECTS = DEF_MAX_OBJECTS,
    parameter int ADDR_BITS   = DEF_ADDR_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl,
    output sts_t              sts,
    input  logic [ADDR_W-1:0] obj_addr,
    input  logic [ADDR_W-1:0] base_addr,
    input  logic [SIZE_W-1:0] size_eff,
    input  logic [CNT_W-1:0]  slot_cnt,
    output logic [ADDR_W-1:0] result_addr,
    output logic [1:0]        status,
    output logic [CNT_W-1:0]  used_count,
    output logic              is_full,
    output logic              is_empty,
    output logic              done
);

    localparam int DEPTH  = (MAX_OBJECTS + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = IDX_W + WORD_SEL_W;
    localparam int DCNT_W = $clog2(CNT_W);
    localparam logic [63:0] AMASK = {64{1'b1}} >> (64 - ADDR_BITS);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [IDX_W-1:0]     clr_ptr_reg;
    logic [IDX_W-1:0]     scan_ptr_reg;
    logic [IDX_W-1:0]     ev_idx_reg;
    logic                 ev_vld_reg;
    logic [DCNT_W-1:0]    dcnt_reg;
    logic [CNT_W-1:0]     in_use_reg;
    logic                 done_reg;

    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_BITS-1:0] off_reg;
    logic [SPAN_W-1:0]    span_reg;
    logic [SPAN_W-1:0]    rem_reg;
    logic [CNT_W-1:0]     quo_reg;
    logic [SPAN_W-1:0]    prod_reg;
    logic [ADDR_W-1:0]    result_addr_reg;
    logic [1:0]           status_reg;
    logic [CNT_W-1:0]     used_count_reg;
    logic                 is_full_reg;
    logic                 is_empty_reg;

    logic [WORD_SEL_W:0]   lz;
    logic                  hit_any;
    logic [WORD_SEL_W-1:0] hit_bit;
    logic [SLOT_W-1:0]     hit_slot;
    logic                  hit_ok;
    logic                  last_word;
    logic [IDX_W-1:0]      fs_word;
    logic [WORD_SEL_W-1:0] fs_bit;
    logic [63:0]           off_wide;
    logic [63:0]           sum_wide;
    logic [SPAN_W-1:0]     trial;
    logic                  rem_ge;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;

    // allocate scan: evaluate the word read in the previous cycle
    assign lz        = lowest_zero(rd_data_reg);
    assign hit_any   = lz[WORD_SEL_W];
    assign hit_bit   = lz[WORD_SEL_W-1:0];
    assign hit_slot  = {ev_idx_reg, hit_bit};
    assign hit_ok    = hit_any && (32'(hit_slot) < 32'(slot_cnt));
    assign last_word = (32'({ev_idx_reg, {WORD_SEL_W{1'b0}}}) + 32'(WORD_BITS))
                       >= 32'(slot_cnt);

    // free path: slot from the quotient
    assign fs_word = IDX_W'(32'(quo_reg) >> WORD_SEL_W);
    assign fs_bit  = quo_reg[WORD_SEL_W-1:0];

    assign off_wide = ((64'(addr_reg) & AMASK) - (64'(base_addr) & AMASK)) & AMASK;
    assign sum_wide = ((64'(base_addr) & AMASK) + 64'(prod_reg)) & AMASK;

    assign trial  = SPAN_W'(size_eff) << dcnt_reg;
    assign rem_ge = rem_reg >= trial;

    always_comb
    begin
        sts.clr_last  = (clr_ptr_reg == IDX_W'(DEPTH - 1));
        sts.scan_hit  = ev_vld_reg && hit_ok;
        sts.scan_miss = ev_vld_reg && !hit_ok && last_word;
        sts.off_bad   = 64'(off_reg) >= 64'(span_reg);
        sts.div_last  = (dcnt_reg == '0);
        sts.rem_nz    = (rem_reg != '0);
        sts.slot_set  = rd_data_reg[fs_bit];
    end

    // one write port, one read port
    always_comb
    begin
        wr_en   = ctl.clr_step || ctl.alloc_wr || ctl.free_wr;
        wr_addr = clr_ptr_reg;
        wr_data = '0;
        if (ctl.alloc_wr)
        begin
            wr_addr = ev_idx_reg;
            wr_data = rd_data_reg | (WORD_BITS'(1) << hit_bit);
        end
        else if (ctl.free_wr)
        begin
            wr_addr = fs_word;
            wr_data = rd_data_reg & ~(WORD_BITS'(1) << fs_bit);
        end
        rd_en   = ctl.scan_run || ctl.free_rd;
        rd_addr = ctl.scan_run ? scan_ptr_reg : fs_word;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg  <= '0;
            scan_ptr_reg <= '0;
            ev_vld_reg   <= 1'b0;
            dcnt_reg     <= '0;
            in_use_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (ctl.clr_step)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            end
            if (ctl.scan_init)
            begin
                scan_ptr_reg <= '0;
                ev_vld_reg   <= 1'b0;
            end
            else if (ctl.scan_run)
            begin
                scan_ptr_reg <= scan_ptr_reg + 1'b1;
                ev_vld_reg   <= 1'b1;
            end
            if (ctl.div_init)
            begin
                dcnt_reg <= DCNT_W'(CNT_W - 1);
            end
            else if (ctl.div_step)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (ctl.alloc_wr)
            begin
                in_use_reg <= in_use_reg + 1'b1;
            end
            else if (ctl.free_wr && (in_use_reg != '0))
            begin
                in_use_reg <= in_use_reg - 1'b1;
            end
            done_reg <= ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            addr_reg <= obj_addr;
        end
        if (ctl.scan_run)
        begin
            ev_idx_reg <= scan_ptr_reg;
        end
        if (ctl.off_calc)
        begin
            off_reg  <= ADDR_BITS'(off_wide);
            span_reg <= SPAN_W'(slot_cnt) * SPAN_W'(size_eff);
        end
        // restoring division, one quotient bit a cycle, MSB first
        if (ctl.div_init)
        begin
            rem_reg <= SPAN_W'(64'(off_reg));
            quo_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - trial;
            end
            quo_reg[dcnt_reg] <= rem_ge;
        end
        if (ctl.alloc_wr)
        begin
            prod_reg <= SPAN_W'(CNT_W'(hit_slot)) * SPAN_W'(size_eff);
        end
        if (ctl.finish)
        begin
            result_addr_reg <= ctl.fin_sum ? sum_wide[ADDR_W-1:0] : '0;
            status_reg      <= ctl.fin_status;
            used_count_reg  <= in_use_reg;
            is_full_reg     <= (in_use_reg >= slot_cnt);
            is_empty_reg    <= (in_use_reg == '0);
        end
    end

    assign result_addr = result_addr_reg;
    assign status      = status_reg;
    assign used_count  = used_count_reg;
    assign is_full     = is_full_reg;
    assign is_empty    = is_empty_reg;
    assign done        = done_reg;

endmodule

### rtl/slab_bitmap_object_allocator.sv
// ----------------------------------------------------------------------------
// slab_bitmap_object_allocator
// Single-slab allocator of fixed-size objects over an occupancy bitmap.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// for one cycle with done high and must be captured then. After reset the
// bitmap is cleared one 64-slot word a cycle, with busy high; configuration
// writes are taken at any time and should be made only while busy is low.
// An allocate reads one bitmap word per cycle from the lowest slot up and
// reports at the word that holds the lowest free slot; a full slab reports
// at the last word under the slot count. A free is set by the 13-step
// restoring divider that turns the offset into a slot; an address outside
// the slab is rejected before the divider runs, and one off a slot
// boundary, or whose slot is not in use, is rejected after it.
// ----------------------------------------------------------------------------
module slab_bitmap_object_allocator import sbo_pkg::*;
#(
    parameter int MAX_OBJECTS = DEF_MAX_OBJECTS,
    parameter int ADDR_BITS   = DEF_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cmd,
    input  logic [ADDR_W-1:0]     obj_addr,
    output logic                  done,
    output logic [ADDR_W-1:0]     result_addr,
    output logic [1:0]            status,
    output logic [CNT_W-1:0]      used_count,
    output logic                  is_full,
    output logic                  is_empty,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [ADDR_W-1:0] base_addr_reg;
    logic [SIZE_W-1:0] obj_size_reg;
    logic [CNT_W-1:0]  num_objects_reg;
    logic [SIZE_W-1:0] size_eff;
    logic [CNT_W-1:0]  slot_cnt;
    ctl_t              ctl;
    sts_t              sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg   <= '0;
            obj_size_reg    <= RST_OBJ_SIZE;
            num_objects_reg <= RST_NUM_OBJECTS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_ADDR:   base_addr_reg   <= ADDR_W'(cfg_data);
                REG_OBJ_SIZE:    obj_size_reg    <= cfg_data[SIZE_W-1:0];
                REG_NUM_OBJECTS: num_objects_reg <= cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // zero size acts as one byte; slot count saturates at MAX_OBJECTS
    assign size_eff = (obj_size_reg == '0) ? SIZE_W'(1) : obj_size_reg;
    assign slot_cnt = (32'(num_objects_reg) > 32'(MAX_OBJECTS)) ?
                      CNT_W'(MAX_OBJECTS) : num_objects_reg;

    sbo_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    sbo_dp
    #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .ADDR_BITS   (ADDR_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .obj_addr    (obj_addr),
        .base_addr   (base_addr_reg),
        .size_eff    (size_eff),
        .slot_cnt    (slot_cnt),
        .result_addr (result_addr),
        .status      (status),
        .used_count  (used_count),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .done        (done)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while request still in progress");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (result_addr == '0))
        else $error("failed request returned a nonzero address");

    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a request in progress");

endmodule

### tb/slab_bitmap_object_allocator_tb.sv
// ----------------------------------------------------------------------------
// slab_bitmap_object_allocator_tb
// Self-checking bench for the slab allocator. A directed table covers
// register extremes, the zero and saturated slot counts, lowered counts
// with slots still held, address wrap and the free error paths. Random
// phases of allocate and free traffic follow, each under its own slab
// setting. Results are checked against the table or a bitmap shadow.
// ----------------------------------------------------------------------------
module slab_bitmap_object_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sbo_pkg::*;

    localparam int  CLK_PERIOD  = 10;
    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  TAIL_CYCLES = 80;
    localparam int  SLAB_BOUND  = DEF_MAX_OBJECTS;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        st;
        logic [CNT_W-1:0]  used;
        logic              full;
        logic              empty;
    } outcome_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  c;
        logic [REG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        outcome_t              want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  cmd;
    logic [ADDR_W-1:0]     obj_addr;
    logic                  done;
    logic [ADDR_W-1:0]     result_addr;
    logic [1:0]            status;
    logic [CNT_W-1:0]      used_count;
    logic                  is_full;
    logic                  is_empty;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow of the slab
    logic [SLAB_BOUND-1:0] slot_map;
    int unsigned           used_slots;
    logic [ADDR_W-1:0]     cfg_base;
    logic [SIZE_W-1:0]     cfg_size;
    logic [CNT_W-1:0]      cfg_count;

    outcome_t    pending_outcomes[$];
    stim_row_t   directed[$];
    int          mismatches = 0;
    int          sender_idle_pct;
    int unsigned cycles = 0;

    slab_bitmap_object_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .obj_addr    (obj_addr),
        .done        (done),
        .result_addr (result_addr),
        .status      (status),
        .used_count  (used_count),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned eff_slots();
        return (int'(cfg_count) > SLAB_BOUND) ? SLAB_BOUND : int'(cfg_count);
    endfunction

    function automatic longint unsigned eff_size();
        return (cfg_size == '0) ? 64'd1 : 64'(cfg_size);
    endfunction

    task automatic predict_slab_request(input logic c, input logic [ADDR_W-1:0] a,
                                        output outcome_t o);
        int unsigned       n;
        int unsigned       slot;
        longint unsigned   sz;
        longint unsigned   off;
        longint unsigned   span;
        logic [ADDR_W-1:0] delta;
        logic              found;
        n = eff_slots();
        sz = eff_size();
        o = '0;
        found = 1'b0;
        if (c == CMD_ALLOC)
        begin
            o.st = ST_FULL;
            // first fit over the live slots only
            for (int i = 0; i < n; i++)
            begin
                if (!found && !slot_map[i])
                begin
                    found = 1'b1;
                    slot_map[i] = 1'b1;
                    used_slots++;
                    o.addr = 32'(64'(cfg_base) + 64'(i) * sz);
                    o.st = ST_OK;
                end
            end
        end
        else
        begin
            delta = a - cfg_base;
            off = 64'(delta);
            span = 64'(n) * sz;
            if (off >= span || (off % sz) != 0)
            begin
                o.st = ST_BADADDR;
            end
            else
            begin
                slot = int'(off / sz);
                if (!slot_map[slot])
                begin
                    o.st = ST_NOTALLOC;
                end
                else
                begin
                    slot_map[slot] = 1'b0;
                    if (used_slots > 0) used_slots--;
                    o.st = ST_OK;
                end
            end
        end
        o.used = 13'(used_slots);
        o.full = (used_slots >= n);
        o.empty = (used_slots == 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // result side: one word per done strobe, no backpressure possible
    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result with no request outstanding: addr 0x%0h status %0d",
                       result_addr, status);
                mismatches++;
            end
            else
            begin
                exp_o = pending_outcomes.pop_front();
                check_field("result_addr", exp_o.addr, result_addr);
                check_field("status", 32'(exp_o.st), 32'(status));
                check_field("used_count", 32'(exp_o.used), 32'(used_count));
                check_field("is_full", 32'(exp_o.full), 32'(is_full));
                check_field("is_empty", 32'(exp_o.empty), 32'(is_empty));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("slab_bitmap_object_allocator: mismatch");
            $finish;
        end
    end

    task automatic send_request(input logic c, input logic [ADDR_W-1:0] a,
                                input logic typed, input outcome_t want);
        outcome_t predicted;
        while ($urandom_range(99, 0) < sender_idle_pct) @(negedge clk);
        start = 1'b1;
        cmd = c;
        obj_addr = a;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_slab_request(c, a, predicted);
        pending_outcomes.push_back(typed ? want : predicted);
        @(negedge clk);
        start = 1'b0;
    endtask

    // hold until the block is idle and every result is in
    task automatic wait_drained();
        @(posedge clk);
        while (pending_outcomes.size() != 0 || busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_BASE_ADDR:   cfg_base = val;
            REG_OBJ_SIZE:    cfg_size = val[SIZE_W-1:0];
            REG_NUM_OBJECTS: cfg_count = val[CNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic row_cfg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = val;
        directed.push_back(r);
    endtask

    task automatic row_req(input logic c, input logic [ADDR_W-1:0] a);
        stim_row_t r;
        r = '0;
        r.kind = ROW_REQ;
        r.c = c;
        r.data = a;
        directed.push_back(r);
    endtask

    task automatic row_exp(input logic c, input logic [ADDR_W-1:0] a,
                           input logic [ADDR_W-1:0] ra, input logic [1:0] st,
                           input int used, input logic full, input logic empty);
        stim_row_t r;
        r = '0;
        r.kind = ROW_REQ;
        r.c = c;
        r.data = a;
        r.typed = 1'b1;
        r.want.addr = ra;
        r.want.st = st;
        r.want.used = 13'(used);
        r.want.full = full;
        r.want.empty = empty;
        directed.push_back(r);
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] b, input logic [SIZE_W-1:0] s,
                             input logic [CNT_W-1:0] n, input int words, input int idle_pct);
        int              pick;
        int unsigned     slot;
        longint unsigned sz;
        logic [31:0]     a;
        write_reg(REG_BASE_ADDR, b);
        write_reg(REG_OBJ_SIZE, 32'(s));
        write_reg(REG_NUM_OBJECTS, 32'(n));
        sender_idle_pct = idle_pct;
        sz = eff_size();
        for (int k = 0; k < words; k++)
        begin
            pick = $urandom_range(99, 0);
            a = $urandom();
            // allocated slots sit low under first fit, so aim frees there
            slot = $urandom_range(used_slots + 1, 0);
            if (pick < 48)
            begin
                send_request(CMD_ALLOC, a, 1'b0, '0);
            end
            else if (pick < 78)
            begin
                send_request(CMD_FREE, cfg_base + 32'(64'(slot) * sz), 1'b0, '0);
            end
            else if (pick < 88 && sz > 1)
            begin
                a = cfg_base + 32'(64'(slot) * sz) + $urandom_range(32'(sz - 1), 1);
                send_request(CMD_FREE, a, 1'b0, '0);
            end
            else
            begin
                send_request(CMD_FREE, a, 1'b0, '0);
            end
            if ($urandom_range(63, 0) == 0) wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_ALLOC;
        obj_addr = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE_ADDR;
        cfg_data = '0;
        sender_idle_pct = 22;
        slot_map = '0;
        used_slots = 0;
        cfg_base = '0;
        cfg_size = RST_OBJ_SIZE;
        cfg_count = RST_NUM_OBJECTS;

        // reset values: base 0, 32-byte objects, 4096 slots
        row_exp(CMD_ALLOC, 32'h0000_0000, 32'h0, ST_OK, 1, 1'b0, 1'b0);
        row_exp(CMD_FREE,  32'h0000_0000, 32'h0, ST_OK, 0, 1'b0, 1'b1);
        row_exp(CMD_FREE,  32'h0000_0000, 32'h0, ST_NOTALLOC, 0, 1'b0, 1'b1);
        row_exp(CMD_FREE,  32'h0000_0010, 32'h0, ST_BADADDR, 0, 1'b0, 1'b1);
        row_exp(CMD_FREE,  32'd131072,    32'h0, ST_BADADDR, 0, 1'b0, 1'b1);
        row_exp(CMD_FREE,  32'd131040,    32'h0, ST_NOTALLOC, 0, 1'b0, 1'b1);
        row_exp(CMD_ALLOC, 32'hFFFF_FFFF, 32'h0, ST_OK, 1, 1'b0, 1'b0);
        row_exp(CMD_ALLOC, 32'h0000_0000, 32'd32, ST_OK, 2, 1'b0, 1'b0);
        row_cfg(REG_NUM_OBJECTS, 32'd2);
        row_exp(CMD_ALLOC, 32'h0000_0000, 32'h0, ST_FULL, 2, 1'b1, 1'b0);
        // slot 1 stays held above the lowered count
        row_cfg(REG_NUM_OBJECTS, 32'd1);
        row_exp(CMD_FREE,  32'd32,        32'h0, ST_BADADDR, 2, 1'b1, 1'b0);
        row_exp(CMD_FREE,  32'h0000_0000, 32'h0, ST_OK, 1, 1'b1, 1'b0);
        row_exp(CMD_ALLOC, 32'h0000_0000, 32'h0, ST_OK, 2, 1'b1, 1'b0);
        row_cfg(REG_NUM_OBJECTS, 32'd0);
        row_exp(CMD_ALLOC, 32'h0000_0000, 32'h0, ST_FULL, 2, 1'b1, 1'b0);
        row_exp(CMD_FREE,  32'h0000_0000, 32'h0, ST_BADADDR, 2, 1'b1, 1'b0);
        // count above the bound saturates
        row_cfg(REG_NUM_OBJECTS, 32'd8191);
        row_exp(CMD_ALLOC, 32'h0000_0000, 32'd64, ST_OK, 3, 1'b0, 1'b0);
        row_exp(CMD_FREE,  32'd32,        32'h0, ST_OK, 2, 1'b0, 1'b0);
        row_exp(CMD_FREE,  32'h0000_0000, 32'h0, ST_OK, 1, 1'b0, 1'b0);
        row_exp(CMD_FREE,  32'd64,        32'h0, ST_OK, 0, 1'b0, 1'b1);
        row_cfg(REG_NUM_OBJECTS, 32'd0);
        row_exp(CMD_ALLOC, 32'h0000_0000, 32'h0, ST_FULL, 0, 1'b1, 1'b1);
        // size zero acts as one; slot 1 wraps to address zero
        row_cfg(REG_NUM_OBJECTS, 32'd4096);
        row_cfg(REG_BASE_ADDR, 32'hFFFF_FFFF);
        row_cfg(REG_OBJ_SIZE, 32'd0);
        row_exp(CMD_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF, ST_OK, 1, 1'b0, 1'b0);
        row_exp(CMD_ALLOC, 32'h0000_0000, 32'h0, ST_OK, 2, 1'b0, 1'b0);
        row_exp(CMD_FREE,  32'h0000_0000, 32'h0, ST_OK, 1, 1'b0, 1'b0);
        row_exp(CMD_FREE,  32'hFFFF_FFFF, 32'h0, ST_OK, 0, 1'b0, 1'b1);
        row_exp(CMD_FREE,  32'h0000_0001, 32'h0, ST_NOTALLOC, 0, 1'b0, 1'b1);
        row_cfg(REG_OBJ_SIZE, 32'd131072);
        row_cfg(REG_BASE_ADDR, 32'h1234_5678);
        row_req(CMD_ALLOC, 32'h0000_0000);
        row_req(CMD_ALLOC, 32'hFFFF_FFFF);
        row_req(CMD_FREE,  32'h1236_5678);
        row_req(CMD_FREE,  32'h3234_5678);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[r])
        begin
            if (directed[r].kind == ROW_CFG)
            begin
                write_reg(directed[r].idx, directed[r].data);
            end
            else
            begin
                send_request(directed[r].c, directed[r].data, directed[r].typed,
                             directed[r].want);
            end
        end

        run_phase($urandom(), 18'd16, 13'd40, 140, 22);
        run_phase(32'hFFFF_FFF0, 18'd0, 13'd64, 140, 22);
        run_phase($urandom(), 18'd131072, 13'd12, 120, 22);
        run_phase(32'h0000_0000, 18'd24, 13'd4096, 140, 66);
        // lower the count with slots above it still held
        run_phase(32'h0000_0000, 18'd24, 13'd5, 120, 66);
        run_phase($urandom(), 18'($urandom_range(131072, 1)), 13'd8191, 130, 66);
        run_phase($urandom(), 18'($urandom_range(300, 1)), 13'($urandom_range(100, 1)),
                  150, 0);
        run_phase($urandom(), 18'd8, 13'd0, 40, 0);
        run_phase(32'hFFFF_FFFF, 18'd7, 13'd3, 100, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("slab_bitmap_object_allocator: match");
        end
        else
        begin
            $display("slab_bitmap_object_allocator: mismatch");
        end
        $finish;
    end

endmodule
